FILE: design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, widths and the arctangent table for the quaternion to Euler
// angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 14;

  localparam int QW  = 16;
  localparam int PW  = 2 * QW;
  localparam int SW  = (2 * FRAC_BITS + 3 > PW + 2) ? 2 * FRAC_BITS + 3 : PW + 2;
  localparam int CW  = SW + 3;
  localparam int AW  = 32;
  localparam int S30W = 32;
  localparam int RADW = 62;
  localparam int ISQRT_STEPS = 31;
  localparam int ROOTW = 31;

  localparam int S30_SHR = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int S30_SHL = (2 * FRAC_BITS >= 30) ? 0 : 30 - 2 * FRAC_BITS;

  localparam logic signed [SW-1:0] ONE_SUM = SW'(1) <<< (2 * FRAC_BITS);
  localparam logic signed [AW-1:0] HALF_PI_ANG = AW'(32'h4000_0000);
  localparam logic [AW-1:0] ROUND_ANG = AW'(32768);
  localparam logic signed [QW-1:0] PITCH_POS_LIMIT = 16'sd16384;
  localparam logic signed [QW-1:0] PITCH_NEG_LIMIT = -16'sd16384;

  typedef struct packed {
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
    logic signed [QW-1:0] qw;
  } qte_in_t;

  typedef struct packed {
    logic signed [QW-1:0] roll;
    logic signed [QW-1:0] pitch;
    logic signed [QW-1:0] yaw;
    logic                 pitch_clamped;
  } qte_out_t;

  typedef struct packed {
    logic signed [SW-1:0]   sr;
    logic signed [SW-1:0]   cr;
    logic signed [SW-1:0]   sy;
    logic signed [SW-1:0]   cy;
    logic signed [S30W-1:0] s30;
    logic                   clamped;
    logic                   neg;
  } qte_side_t;

  typedef struct packed {
    logic en;
    logic vld;
  } qte_ctrl_t;

  function automatic logic [AW-1:0] atan_entry(input int unsigned idx);
    logic [AW-1:0] v;
    case (idx)
      0:  v = 32'h2000_0000;
      1:  v = 32'h12E4_051E;
      2:  v = 32'h09FB_385B;
      3:  v = 32'h0511_11D4;
      4:  v = 32'h028B_0D43;
      5:  v = 32'h0145_D7E1;
      6:  v = 32'h00A2_F61E;
      7:  v = 32'h0051_7C55;
      8:  v = 32'h0028_BE53;
      9:  v = 32'h0014_5F2F;
      10: v = 32'h000A_2F98;
      11: v = 32'h0005_17CC;
      12: v = 32'h0002_8BE6;
      13: v = 32'h0001_45F3;
      14: v = 32'h0000_A2FA;
      15: v = 32'h0000_517D;
      16: v = 32'h0000_28BE;
      17: v = 32'h0000_145F;
      18: v = 32'h0000_0A30;
      19: v = 32'h0000_0518;
      20: v = 32'h0000_028C;
      21: v = 32'h0000_0146;
      22: v = 32'h0000_00A3;
      23: v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front
// Three register stages: component products, the rotation matrix sums with
// the pitch clamp test, and one minus the square of the pitch sine.
// ----------------------------------------------------------------------------
module qte_front import qte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qte_ctrl_t         ctrl_i,
  input  qte_in_t           data_i,
  output logic              vld_o,
  output logic [RADW-1:0]   rad_o,
  output qte_side_t         side_o
);

  logic signed [PW-1:0] wx_q, yz_q, xx_q, yy_q, wz_q, xy_q, zz_q, wy_q, zx_q;
  logic                 v1_q, v2_q, v3_q;
  qte_side_t            side2_d, side2_q, side3_q;
  logic signed [SW-1:0] sp;
  logic signed [SW-1:0] s30_full;
  logic signed [2*S30W-1:0] sq;
  logic [RADW-1:0]      rad_d, rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (ctrl_i.en) begin
      v1_q <= ctrl_i.vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    side2_d.sr = (SW'(wx_q) + SW'(yz_q)) <<< 1;
    side2_d.cr = ONE_SUM - ((SW'(xx_q) + SW'(yy_q)) <<< 1);
    side2_d.sy = (SW'(wz_q) + SW'(xy_q)) <<< 1;
    side2_d.cy = ONE_SUM - ((SW'(yy_q) + SW'(zz_q)) <<< 1);
    sp = (SW'(wy_q) - SW'(zx_q)) <<< 1;
    s30_full = (2 * FRAC_BITS >= 30) ? (sp >>> S30_SHR) : (sp <<< S30_SHL);
    side2_d.s30 = s30_full[S30W-1:0];
    side2_d.clamped = (sp >= ONE_SUM) || (sp <= -ONE_SUM);
    side2_d.neg = sp[SW-1];
  end

  assign sq    = side2_q.s30 * side2_q.s30;
  assign rad_d = (RADW'(1) << 60) - sq[RADW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      wx_q <= data_i.qw * data_i.qx;
      yz_q <= data_i.qy * data_i.qz;
      xx_q <= data_i.qx * data_i.qx;
      yy_q <= data_i.qy * data_i.qy;
      wz_q <= data_i.qw * data_i.qz;
      xy_q <= data_i.qx * data_i.qy;
      zz_q <= data_i.qz * data_i.qz;
      wy_q <= data_i.qw * data_i.qy;
      zx_q <= data_i.qz * data_i.qx;
      side2_q <= side2_d;
      side3_q <= side2_q;
      rad_q   <= rad_d;
    end
  end

  assign vld_o  = v3_q;
  assign rad_o  = rad_q;
  assign side_o = side3_q;

endmodule

FILE: design/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt
// Pipelined integer square root, one result bit per register stage, with
// the remaining operands carried alongside.
// ----------------------------------------------------------------------------
module qte_isqrt import qte_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qte_ctrl_t         ctrl_i,
  input  logic [RADW-1:0]   rad_i,
  input  qte_side_t         side_i,
  output logic              vld_o,
  output logic [ROOTW-1:0]  root_o,
  output qte_side_t         side_o
);

  logic [RADW-1:0] v_q    [ISQRT_STEPS];
  logic [RADW-1:0] r_q    [ISQRT_STEPS];
  qte_side_t       side_q [ISQRT_STEPS];
  logic            vld_q  [ISQRT_STEPS];

  for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
    localparam logic [RADW-1:0] BIT = RADW'(1) << (60 - 2 * k);
    logic [RADW-1:0] v_in, r_in, t, v_d, r_d;
    qte_side_t       s_in;
    logic            vl_in;

    if (k == 0) begin : g_first
      assign v_in  = rad_i;
      assign r_in  = '0;
      assign s_in  = side_i;
      assign vl_in = ctrl_i.vld;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign r_in  = r_q[k-1];
      assign s_in  = side_q[k-1];
      assign vl_in = vld_q[k-1];
    end

    always_comb begin
      t = r_in + BIT;
      if (v_in >= t) begin
        v_d = v_in - t;
        r_d = (r_in >> 1) + BIT;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[k] <= vl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        v_q[k]    <= v_d;
        r_q[k]    <= r_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign vld_o  = vld_q[ISQRT_STEPS-1];
  assign root_o = r_q[ISQRT_STEPS-1][ROOTW-1:0];
  assign side_o = side_q[ISQRT_STEPS-1];

endmodule

FILE: design/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined CORDIC vectoring unit giving atan2(y, x) as a 16-bit binary
// angle: a quadrant stage followed by one register stage per iteration.
// ----------------------------------------------------------------------------
module qte_cordic import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  qte_ctrl_t            ctrl_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] x_i,
  output logic                 vld_o,
  output logic signed [QW-1:0] angle_o
);

  localparam int NS = CORDIC_STAGES + 1;

  logic signed [CW-1:0] x_q   [NS];
  logic signed [CW-1:0] y_q   [NS];
  logic signed [AW-1:0] a_q   [NS];
  logic                 z_q   [NS];
  logic                 vld_q [NS];

  logic signed [CW-1:0] x0, y0;
  logic signed [AW-1:0] a0;
  logic [AW-1:0]        a_rnd;

  always_comb begin
    x0 = x_i;
    y0 = y_i;
    a0 = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0 = y_i;
        y0 = -x_i;
        a0 = HALF_PI_ANG;
      end else begin
        x0 = -y_i;
        y0 = x_i;
        a0 = -HALF_PI_ANG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (ctrl_i.en) begin
      vld_q[0] <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      a_q[0] <= a0;
      z_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_iter
    localparam int I = k - 1;
    localparam logic [AW-1:0] ATAN = atan_entry(I);
    logic signed [CW-1:0] dx, dy, x_d, y_d;
    logic signed [AW-1:0] a_d;

    always_comb begin
      dx = y_q[k-1] >>> I;
      dy = x_q[k-1] >>> I;
      if (y_q[k-1] > 0) begin
        x_d = x_q[k-1] + dx;
        y_d = y_q[k-1] - dy;
        a_d = a_q[k-1] + ATAN;
      end else begin
        x_d = x_q[k-1] - dx;
        y_d = y_q[k-1] + dy;
        a_d = a_q[k-1] - ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        x_q[k] <= x_d;
        y_q[k] <= y_d;
        a_q[k] <= a_d;
        z_q[k] <= z_q[k-1];
      end
    end
  end

  assign a_rnd   = a_q[NS-1] + ROUND_ANG;
  assign angle_o = z_q[NS-1] ? '0 : a_rnd[AW-1:AW-QW];
  assign vld_o   = vld_q[NS-1];

endmodule

FILE: design/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q1.14 quaternion into roll, pitch and yaw binary angles.
// ----------------------------------------------------------------------------
// The input channel carries one quaternion per transfer, the output channel
// one set of roll, pitch and yaw angles with the pitch clamp flag. Both use
// valid and stall; a transfer happens on a clock edge with valid high and
// stall low. Every item passes through a fixed pipeline: three stages of
// products, sums and squaring, 31 stages of square root, 17 stages of
// CORDIC vectoring and the output register. One quaternion is taken every
// cycle for as long as the output is not stalled; the pipeline length is
// set by the one bit per stage square root and the one iteration per stage
// CORDIC units. While the output register holds a result and stall_i is
// high, the whole pipeline holds and stall_o is raised, so nothing is lost
// or repeated.
// Reset clears all valid bits; the first quaternion may be sent in the cycle
// after reset is released.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles import qte_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  qte_in_t  data_i,
  output logic     valid_o,
  input  logic     stall_i,
  output qte_out_t data_o
);

  localparam int NS = CORDIC_STAGES + 1;

  logic            en;
  qte_ctrl_t       c_front, c_sqrt, c_cor;
  logic            f_vld, s_vld, r_vld, p_vld, y_vld;
  logic [RADW-1:0] rad;
  qte_side_t       f_side, s_side;
  logic [ROOTW-1:0] root;
  logic signed [QW-1:0] roll_a, pitch_a, yaw_a;
  logic            clamp_q [NS];
  logic            neg_q   [NS];
  qte_out_t        out_d, out_q;
  logic            out_vld_q;

  assign en      = !out_vld_q || !stall_i;
  assign stall_o = !en;

  assign c_front = '{en: en, vld: valid_i};
  assign c_sqrt  = '{en: en, vld: f_vld};
  assign c_cor   = '{en: en, vld: s_vld};

  qte_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (c_front),
    .data_i (data_i),
    .vld_o  (f_vld),
    .rad_o  (rad),
    .side_o (f_side)
  );

  qte_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (c_sqrt),
    .rad_i  (rad),
    .side_i (f_side),
    .vld_o  (s_vld),
    .root_o (root),
    .side_o (s_side)
  );

  qte_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (c_cor),
    .y_i     (CW'(s_side.sr)),
    .x_i     (CW'(s_side.cr)),
    .vld_o   (r_vld),
    .angle_o (roll_a)
  );

  qte_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (c_cor),
    .y_i     (CW'(s_side.s30)),
    .x_i     ({{(CW-ROOTW){1'b0}}, root}),
    .vld_o   (p_vld),
    .angle_o (pitch_a)
  );

  qte_cordic u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (c_cor),
    .y_i     (CW'(s_side.sy)),
    .x_i     (CW'(s_side.cy)),
    .vld_o   (y_vld),
    .angle_o (yaw_a)
  );

  for (genvar k = 0; k < NS; k++) begin : g_flag
    always_ff @(posedge clk_i) begin
      if (en) begin
        clamp_q[k] <= (k == 0) ? s_side.clamped : clamp_q[(k == 0) ? 0 : k-1];
        neg_q[k]   <= (k == 0) ? s_side.neg     : neg_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_comb begin
    out_d.roll          = roll_a;
    out_d.yaw           = yaw_a;
    out_d.pitch_clamped = clamp_q[NS-1];
    if (clamp_q[NS-1]) begin
      out_d.pitch = neg_q[NS-1] ? PITCH_NEG_LIMIT : PITCH_POS_LIMIT;
    end else begin
      out_d.pitch = pitch_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= p_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_vld == p_vld) && (y_vld == p_vld))
    else $error("CORDIC lanes out of step");

  a_clamp_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.pitch_clamped) |->
      (out_q.pitch == PITCH_POS_LIMIT || out_q.pitch == PITCH_NEG_LIMIT))
    else $error("clamped pitch not at a limit");

  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.pitch >= PITCH_NEG_LIMIT && out_q.pitch <= PITCH_POS_LIMIT))
    else $error("pitch outside half pi");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(out_q) && out_vld_q)
    else $error("result changed while held");

endmodule

FILE: verif/quaternion_to_euler_angles_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_tb
// Drives quaternions into the converter and checks every roll, pitch, yaw
// and clamp flag against a bit-exact predictor of the fixed point CORDIC.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_tb;
  import qte_pkg::*;

  localparam int LATENCY     = 52;
  localparam int N_RANDOM    = 600;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint HALF_PI = 64'sd1073741824;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     valid_i = 1'b0;
  logic     stall_o;
  qte_in_t  data_i = '0;
  logic     valid_o;
  logic     stall_i = 1'b0;
  qte_out_t data_o;

  qte_in_t  pending_q[$];
  qte_out_t angles_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       calm = 1'b0;
  bit       drained_pause = 1'b0;
  bit       in_taken = 1'b0;
  int       hold_left = 0;
  int       hold_long = 0;
  int       gap_left = 0;

  quaternion_to_euler_angles dut (.*);

  always #6 clk_i = ~clk_i;

  function automatic longint shr(longint v, int s);
    if (v < 0) return -1 - ((-1 - v) >>> s);
    return v >>> s;
  endfunction

  function automatic longint root(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] vector_angle(longint y, longint x);
    longint ang, t, dx, dy;
    logic [63:0] u;
    ang = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = HALF_PI;
      end else begin
        t = x; x = -y; y = t; ang = -HALF_PI;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += longint'(atan_entry(i));
      end else begin
        x -= dx; y += dy; ang -= longint'(atan_entry(i));
      end
    end
    u = ang + 64'd32768;
    return u[31:16];
  endfunction

  function automatic qte_out_t euler_of(qte_in_t q);
    qte_out_t r;
    longint x, y, z, w, one, sr, cr, sy, cy, sp, s30;
    x = q.qx; y = q.qy; z = q.qz; w = q.qw;
    one = 64'sd1 <<< (2 * FRAC_BITS);
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    r.pitch_clamped = 1'b0;
    if (sp >= one) begin
      r.pitch = PITCH_POS_LIMIT;
      r.pitch_clamped = 1'b1;
    end else if (sp <= -one) begin
      r.pitch = PITCH_NEG_LIMIT;
      r.pitch_clamped = 1'b1;
    end else begin
      if (2 * FRAC_BITS >= 30) s30 = shr(sp, 2 * FRAC_BITS - 30);
      else s30 = sp * (64'sd1 <<< (30 - 2 * FRAC_BITS));
      r.pitch = vector_angle(s30, root((64'sd1 <<< 60) - s30 * s30));
    end
    r.roll = vector_angle(sr, cr);
    r.yaw  = vector_angle(sy, cy);
    return r;
  endfunction

  function automatic qte_in_t random_quat();
    qte_in_t q;
    int unsigned k;
    k = $urandom_range(0, 9);
    q = {$urandom, $urandom};
    q.qw = 16'($urandom);
    if (k < 5) begin
      q.qx = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.qy = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.qz = 16'($signed($urandom_range(0, 32768)) - 16384);
      q.qw = 16'($signed($urandom_range(0, 32768)) - 16384);
    end else if (k < 7) begin
      q.qx = 16'($signed($urandom_range(0, 64)) - 32);
      q.qz = 16'($signed($urandom_range(0, 64)) - 32);
    end
    return q;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!valid_i || in_taken) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        if (gap_left <= 1 && pending_q.size() > 0 && !drained_pause) begin
          data_i  <= pending_q.pop_front();
          valid_i <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) gap_left <= $urandom_range(2, 7);
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_long > 0) begin
        hold_long <= hold_long - 1;
        stall_i   <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        stall_i   <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        hold_left <= $urandom_range(0, 5);
        stall_i   <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    qte_out_t exp_r;
    cycles <= cycles + 1;
    in_taken <= rst_ni && valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o) angles_q.push_back(euler_of(data_i));
    if (rst_ni && valid_o && !stall_i) begin
      if (angles_q.size() == 0) begin
        $error("unexpected transfer on output");
        errors = errors + 1;
      end else begin
        exp_r = angles_q.pop_front();
        if (data_o.roll !== exp_r.roll) begin
          $error("roll exp %0d act %0d", exp_r.roll, data_o.roll);
          errors = errors + 1;
        end
        if (data_o.pitch !== exp_r.pitch) begin
          $error("pitch exp %0d act %0d", exp_r.pitch, data_o.pitch);
          errors = errors + 1;
        end
        if (data_o.yaw !== exp_r.yaw) begin
          $error("yaw exp %0d act %0d", exp_r.yaw, data_o.yaw);
          errors = errors + 1;
        end
        if (data_o.pitch_clamped !== exp_r.pitch_clamped) begin
          $error("pitch_clamped exp %0d act %0d", exp_r.pitch_clamped,
                 data_o.pitch_clamped);
          errors = errors + 1;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[quaternion_to_euler_angles] ERROR");
      $finish;
    end
  end

  task automatic add_quat(int x, int y, int z, int w);
    qte_in_t q;
    q.qx = 16'(x); q.qy = 16'(y); q.qz = 16'(z); q.qw = 16'(w);
    pending_q.push_back(q);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    add_quat(0, 0, 0, 16384);
    add_quat(0, 0, 0, 0);
    add_quat(16384, 0, 0, 0);
    add_quat(0, 16384, 0, 0);
    add_quat(0, 0, 16384, 0);
    add_quat(11585, 0, 0, 11585);
    add_quat(0, 11585, 0, 11585);
    add_quat(0, -11585, 0, 11585);
    add_quat(0, 11586, 0, 11586);
    add_quat(0, 0, 11585, 11585);
    add_quat(-32768, -32768, -32768, -32768);
    add_quat(32767, 32767, 32767, 32767);
    add_quat(32767, -32768, 32767, -32768);
    add_quat(-32768, 32767, 32767, -32768);
    add_quat(8192, 8192, 8192, 8192);
    add_quat(8192, -8192, 8192, 8192);
    add_quat(0, 0, 1, 0);
    add_quat(1, 0, 0, 1);
    add_quat(12000, 0, 0, -11000);
    add_quat(0, 0, 0, -16384);
    for (int i = 0; i < N_RANDOM / 2; i++) pending_q.push_back(random_quat());
    wait (pending_q.size() == 0);
    hold_long = 150;
    for (int i = 0; i < 120; i++) pending_q.push_back(random_quat());
    wait (pending_q.size() == 0);
    drained_pause = 1'b1;
    @(posedge clk_i);
    wait (angles_q.size() == 0 && !valid_i);
    drained_pause = 1'b0;
    for (int i = 0; i < N_RANDOM / 3; i++) pending_q.push_back(random_quat());
    wait (pending_q.size() < 60);
    calm = 1'b1;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    while (valid_i && stall_o) @(posedge clk_i);
    @(posedge clk_i);
    wait (angles_q.size() == 0);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (errors == 0 && angles_q.size() == 0) begin
      $display("[quaternion_to_euler_angles] OK");
    end else begin
      $display("[quaternion_to_euler_angles] ERROR");
    end
    $finish;
  end
endmodule
